// ===== sv/tridiagonal_system_solver_unit_assert.svh =====
// Assertion macros shared by the sequencer and datapath modules.
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_UNIT_ASSERT_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the trigger.
`define TSS_ASSERT_IMPLY(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define TSS_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tss_pkg.sv =====
package tss_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FACTOR,
    ST_FACTOR_WAIT,
    ST_PIVOT,
    ST_NUM,
    ST_SOL,
    ST_SOL_WAIT,
    ST_BACK_RD,
    ST_BACK_MUL,
    ST_BACK_WR,
    ST_EMIT_RD,
    ST_EMIT
  } tss_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_row;
    logic div_factor;
    logic div_sol;
    logic wr_factor;
    logic upd_pivot;
    logic calc_num;
    logic wr_sol;
    logic back_rd;
    logic back_mul;
    logic back_wr;
    logic emit_rd;
    logic emit_load;
    logic clear_run;
  } tss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic first_row;
    logic run_end;
    logic back_done;
    logic emit_last;
  } tss_stat_t;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [WORD_W+33:0] x);
    logic signed [WORD_W+33:0] hi;
    logic signed [WORD_W+33:0] lo;
    hi = (WORD_W+34)'(2147483647);
    lo = -(WORD_W+34)'(64'sd2147483648);
    if (x > hi) return 32'sh7fffffff;
    if (x < lo) return 32'sh80000000;
    return x[WORD_W-1:0];
  endfunction

endpackage

// ===== sv/tss_div.sv =====
// Signed fixed-point divider, one quotient bit per cycle, magnitude restoring.
module tss_div import tss_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [WORD_W-1:0] num,
  input  logic signed [WORD_W-1:0] den,
  output logic                     done,
  output logic                     zero_div,
  output logic signed [WORD_W-1:0] quo
);
  localparam int unsigned DW = WORD_W + FRAC_BITS;
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0]     dvd_r, dvd_nxt;
  logic [DW-1:0]     q_r, q_nxt;
  logic [WORD_W:0]   rem_r, rem_nxt;
  logic [WORD_W-1:0] dsr_r, dsr_nxt;
  logic              neg_r, neg_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              zero_r, zero_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   shifted;
  logic [DW:0]       qs;

  always_comb begin
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;
    cnt_nxt  = cnt_r;
    shifted  = {rem_r[WORD_W-1:0], dvd_r[DW-1]};
    trial    = shifted - {1'b0, dsr_r};
    if (start) begin
      dvd_nxt  = {(num[WORD_W-1] ? WORD_W'(-num) : WORD_W'(num)), {FRAC_BITS{1'b0}}};
      dsr_nxt  = den[WORD_W-1] ? WORD_W'(-den) : WORD_W'(den);
      neg_nxt  = num[WORD_W-1] ^ den[WORD_W-1];
      rem_nxt  = '0;
      q_nxt    = '0;
      zero_nxt = (den == '0);
      cnt_nxt  = CW'(DW);
      busy_nxt = (den != '0);
      done_nxt = (den == '0);
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DW-2:0], 1'b0};
      if (!trial[WORD_W]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r  <= dvd_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

  always_comb begin
    qs = neg_r ? (DW+1)'(-{1'b0, q_r}) : {1'b0, q_r};
    if (zero_r) quo = '0;
    else quo = sat32((WORD_W+34)'($signed(qs)));
  end

  assign done     = done_r;
  assign zero_div = zero_r;
endmodule

// ===== sv/tss_ctrl.sv =====
// Sequencer for forward sweep, back substitution and result emission.
module tss_ctrl import tss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      out_free,
  input  logic      out_fire,
  input  tss_stat_t stat,
  output logic      in_ready,
  output tss_cmd_t  cmd
);
  `include "tridiagonal_system_solver_unit_assert.svh"

  tss_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:        if (in_fire) state_nxt = stat.first_row ? ST_SOL : ST_FACTOR;
      ST_FACTOR:      state_nxt = ST_FACTOR_WAIT;
      ST_FACTOR_WAIT: if (stat.div_done) state_nxt = ST_PIVOT;
      ST_PIVOT:       state_nxt = ST_NUM;
      ST_NUM:         state_nxt = ST_SOL;
      ST_SOL:         state_nxt = ST_SOL_WAIT;
      ST_SOL_WAIT: begin
        if (stat.div_done) begin
          if (!stat.run_end) state_nxt = ST_IDLE;
          else if (stat.back_done) state_nxt = ST_EMIT_RD;
          else state_nxt = ST_BACK_RD;
        end
      end
      ST_BACK_RD:     state_nxt = ST_BACK_MUL;
      ST_BACK_MUL:    state_nxt = ST_BACK_WR;
      ST_BACK_WR:     state_nxt = stat.back_done ? ST_EMIT_RD : ST_BACK_RD;
      ST_EMIT_RD:     if (out_free) state_nxt = ST_EMIT;
      ST_EMIT:        state_nxt = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
      default:        state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE:        cmd.load_row = in_fire;
      ST_FACTOR:      cmd.div_factor = 1'b1;
      ST_FACTOR_WAIT: cmd.wr_factor = stat.div_done;
      ST_PIVOT:       cmd.upd_pivot = 1'b1;
      ST_NUM:         cmd.calc_num = 1'b1;
      ST_SOL:         cmd.div_sol = 1'b1;
      ST_SOL_WAIT:    cmd.wr_sol = stat.div_done;
      ST_BACK_RD:     cmd.back_rd = 1'b1;
      ST_BACK_MUL:    cmd.back_mul = 1'b1;
      ST_BACK_WR:     cmd.back_wr = 1'b1;
      ST_EMIT_RD:     cmd.emit_rd = out_free;
      ST_EMIT: begin
        cmd.emit_load = 1'b1;
        cmd.clear_run = stat.emit_last;
      end
      default:        cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  `TSS_ASSERT_IMPLY(a_ready_idle, clk, rst_n, in_ready, state_r == ST_IDLE, "ready outside idle")
  `TSS_ASSERT_NEXT(a_emit_after_rd, clk, rst_n, cmd.emit_rd, state_r == ST_EMIT, "emit lost")
  `TSS_ASSERT_IMPLY(a_out_empty_at_emit, clk, rst_n, out_fire && (state_r == ST_EMIT), 1'b0, "overwrite")
endmodule

// ===== sv/tss_dp.sv =====
// Row store, pivot state, multiplier and output register.
module tss_dp import tss_pkg::*; #(
  parameter int unsigned MAX_ROWS  = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tss_cmd_t                 cmd,
  input  logic [4*WORD_W-1:0]      row_data,
  input  logic                     row_last,
  input  logic                     out_take,
  output tss_stat_t                stat,
  output logic                     out_valid,
  output logic                     out_free,
  output logic [IDX_W-1:0]         out_row,
  output logic signed [WORD_W-1:0] out_sol,
  output logic                     out_sing,
  output logic                     out_final
);
  `include "tridiagonal_system_solver_unit_assert.svh"
  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = $clog2(MAX_ROWS + 1);
  localparam int unsigned PW = 2 * WORD_W;
  localparam logic signed [PW-1:0] RND = (PW'(1) <<< FRAC_BITS) - PW'(1);

  logic signed [WORD_W-1:0] fac_mem [MAX_ROWS];
  logic signed [WORD_W-1:0] sol_mem [MAX_ROWS];

  logic signed [WORD_W-1:0] a_r, b_r, c_r, r_r;
  logic signed [WORD_W-1:0] pivot_r, prev_r, g_r, usol_r, num_r;
  logic signed [WORD_W-1:0] fk_r, sk_r, s0_r, prod_r;
  logic [CW-1:0]            cnt_r;
  logic [AW-1:0]            idx_r, k_r;
  logic                     last_r, sing_r, valid_r;
  logic [IDX_W-1:0]         orow_r;
  logic signed [WORD_W-1:0] osol_r;
  logic                     osing_r, ofin_r;
  logic                     div_start, div_done, div_zero;
  logic signed [WORD_W-1:0] div_num, div_den, div_q;
  logic signed [PW-1:0]     mul_p;
  logic signed [PW-1:0]     mul_adj;
  logic signed [WORD_W-1:0] mul_a, mul_b, mul_q;
  logic [AW-1:0]            rd_a;
  logic [AW-1:0]            e_r;

  assign div_start = cmd.div_factor | cmd.div_sol;
  assign div_num   = cmd.div_factor ? prev_r : num_r;
  assign div_den   = pivot_r;

  tss_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .zero_div(div_zero), .quo(div_q)
  );

  // One shared multiplier: a*g, a*u[i-1] or factor*u in back substitution.
  // A negative product is biased before the shift so it truncates toward zero.
  always_comb begin
    mul_a = a_r;
    mul_b = cmd.calc_num ? usol_r : g_r;
    if (cmd.back_mul) begin
      mul_a = fk_r;
      mul_b = sk_r;
    end
    mul_p   = mul_a * mul_b;
    mul_adj = mul_p[PW-1] ? (mul_p + RND) : mul_p;
    mul_q   = sat32((WORD_W+34)'(mul_adj >>> FRAC_BITS));
  end

  assign rd_a = cmd.back_rd ? k_r : e_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_factor) fac_mem[idx_r] <= div_q;
    if (cmd.wr_sol) sol_mem[idx_r] <= div_q;
    else if (cmd.back_wr) sol_mem[AW'(k_r - 1'b1)] <=
      sat32((WORD_W+34)'(s0_r) - (WORD_W+34)'(prod_r));
    if (cmd.back_rd || cmd.emit_rd) begin
      fk_r <= fac_mem[rd_a];
      sk_r <= sol_mem[rd_a];
      s0_r <= sol_mem[AW'(rd_a - 1'b1)];
    end
  end

  // Forward sweep sets num_r from rhs on row 0 at load time.
  always_ff @(posedge clk) begin
    if (cmd.load_row) begin
      {r_r, c_r, b_r, a_r} <= row_data;
      last_r <= row_last;
      idx_r  <= cnt_r[AW-1:0];
      if (cnt_r == '0) begin
        pivot_r <= row_data[2*WORD_W-1:WORD_W];
        num_r   <= row_data[4*WORD_W-1:3*WORD_W];
      end
    end
    if (cmd.wr_factor) g_r <= div_q;
    if (cmd.upd_pivot) pivot_r <= sat32((WORD_W+34)'(b_r) - (WORD_W+34)'(mul_q));
    if (cmd.calc_num) num_r <= sat32((WORD_W+34)'(r_r) - (WORD_W+34)'(mul_q));
    if (cmd.wr_sol) usol_r <= div_q;
    if (cmd.back_mul) prod_r <= mul_q;
    if (cmd.emit_load) begin
      orow_r  <= IDX_W'(e_r);
      osol_r  <= sk_r;
      osing_r <= sing_r;
      ofin_r  <= (e_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      sing_r  <= 1'b0;
      valid_r <= 1'b0;
      prev_r  <= '0;
      k_r     <= '0;
      e_r     <= '0;
    end else begin
      if (cmd.load_row) cnt_r <= cnt_r + 1'b1;
      if ((cmd.wr_factor || cmd.wr_sol) && div_zero) sing_r <= 1'b1;
      if (cmd.wr_sol) begin
        prev_r <= c_r;
        k_r    <= idx_r;
        e_r    <= idx_r;
      end
      if (cmd.back_wr) k_r <= k_r - 1'b1;
      if (cmd.emit_load) e_r <= e_r - 1'b1;
      if (cmd.clear_run) begin
        cnt_r  <= '0;
        sing_r <= 1'b0;
        prev_r <= '0;
      end
      if (cmd.emit_load) valid_r <= 1'b1;
      else if (out_take) valid_r <= 1'b0;
    end
  end

  // Status back to the sequencer.
  assign stat.div_done  = div_done;
  assign stat.first_row = (cnt_r == '0);
  assign stat.run_end   = last_r || (cnt_r == CW'(MAX_ROWS));
  assign stat.back_done = cmd.wr_sol ? (idx_r == '0) : (k_r == AW'(1));
  assign stat.emit_last = (e_r == '0);

  assign out_valid = valid_r;
  assign out_free  = !valid_r || out_take;
  assign out_row   = orow_r;
  assign out_sol   = osol_r;
  assign out_sing  = osing_r;
  assign out_final = ofin_r;

  `TSS_ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit_load, out_valid, "no result")
  `TSS_ASSERT_IMPLY(a_div_seq, clk, rst_n, div_start, !div_done, "div overlap")
  `TSS_ASSERT_IMPLY(a_final_row, clk, rst_n, out_valid && out_final, out_row == '0, "final")
endmodule

// ===== sv/tridiagonal_system_solver_unit.sv =====
// Each row after row 0 runs a factor divide, a pivot update, a numerator update and
// a solution divide in turn before the next row is accepted; row 0 needs only the
// solution divide. Rows are taken one at a time, bounded by the bit-serial divider;
// after the last row, back substitution reads, multiplies and writes each row, and
// emission reads each result and loads it once the output register is free.
// Reset (rst_n low, synchronous) clears the sequencer, row count and flags.
module tridiagonal_system_solver_unit import tss_pkg::*; #(
  parameter int unsigned MAX_ROWS  = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // sub_diag[31:0], main_diag[63:32], super_diag[95:64], rhs[127:96]
  input  logic [127:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // row_index[5:0], solution[37:6], singular[38], zeros above
  output logic [39:0]  out_tdata,
  output logic         out_tlast
);
  tss_cmd_t  cmd;
  tss_stat_t stat;
  logic in_fire, out_free, out_take;
  logic [IDX_W-1:0] orow;
  logic signed [WORD_W-1:0] osol;
  logic osing;

  assign in_fire  = in_tvalid && in_tready;
  assign out_take = out_tvalid && out_tready;

  tss_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
    .out_fire(out_take), .stat(stat), .in_ready(in_tready), .cmd(cmd)
  );

  tss_dp #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .row_data(in_tdata), .row_last(in_tlast),
    .out_take(out_take), .stat(stat), .out_valid(out_tvalid), .out_free(out_free),
    .out_row(orow), .out_sol(osol), .out_sing(osing), .out_final(out_tlast)
  );

  assign out_tdata = {1'b0, osing, osol, orow};
endmodule
